// ===== sv/rpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Random page replacement package
// Shared constants, types and helper functions of the page replacement core.
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int MAX_DRAWS = 16;
  localparam int SLOT_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int PAGE_W    = 32;
  localparam int CFG_W     = 32;
  localparam int TOTAL_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int DRAW_W    = $clog2(MAX_DRAWS);
  localparam int STEP_W    = $clog2(PAGE_W);
  localparam int OUT_W     = ((PAGE_W + SLOT_W + 2 + 7) / 8) * 8;

  localparam logic [PAGE_W-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_CHK,
    ST_WR
  } state_e;

  function automatic logic [PAGE_W-1:0] lfsr_next(input logic [PAGE_W-1:0] cur);
    logic [PAGE_W-1:0] nxt;
    nxt = cur >> 1;
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

  function automatic logic [PAGE_W-1:0] seed_value(input logic [PAGE_W-1:0] s);
    return (s != '0) ? s : PAGE_W'(1);
  endfunction

endpackage

// ===== sv/random_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// Random page replacement core
// Fill phase: the fault is written into the next free slot and its result is
// registered. Replacement: each draw starts the serial modulo on the advanced
// LFSR value, reads the table and compares, with at most sixteen draws per fault.
// One item at a time; a waiting result does not block the next input transfer.
// Reset clears fill count and previous page, sets 1024 slots and the LFSR to 1.
// ----------------------------------------------------------------------------
module random_page_replacement_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rpr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // fault_page [31:0]
  input  logic [rpr_pkg::PAGE_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // evict_page [31:0], slot_used [41:32], evict_dirty [42],
  // new_page_writable [43], zero fill above
  output logic [rpr_pkg::OUT_W-1:0]     m_axis_tdata,
  // evict_valid [0]
  output logic                          m_axis_tuser
);

  rpr_pkg::state_e state_q, state_d;

  logic [rpr_pkg::TOTAL_W-1:0] total_q;
  logic [rpr_pkg::PAGE_W-1:0]  lfsr_q;
  logic [rpr_pkg::CNT_W-1:0]   fill_q;
  logic [rpr_pkg::PAGE_W-1:0]  last_q;
  logic                        last_vld_q;
  logic [rpr_pkg::PAGE_W-1:0]  page_q;
  logic [rpr_pkg::SLOT_W-1:0]  slot_q;
  logic [rpr_pkg::PAGE_W-1:0]  victim_q;
  logic                        evict_q;
  logic [rpr_pkg::DRAW_W-1:0]  draw_q;
  logic                        out_vld_q;
  logic                        out_evict_q;
  logic [rpr_pkg::PAGE_W-1:0]  out_page_q;
  logic [rpr_pkg::SLOT_W-1:0]  out_slot_q;

  logic [rpr_pkg::CNT_W-1:0]   slots;
  logic [rpr_pkg::PAGE_W-1:0]  lfsr_adv;
  logic                        in_fire;
  logic                        cfg_fire;
  logic                        full;
  logic                        redraw;
  logic                        out_free;
  logic                        mod_start;
  logic                        mod_done;
  logic [rpr_pkg::SLOT_W-1:0]  mod_rem;
  logic                        ram_re;
  logic                        ram_we;
  logic                        out_load;
  logic [rpr_pkg::PAGE_W-1:0]  ram_rdata;

  always_comb begin
    if (total_q < rpr_pkg::TOTAL_W'(2)) begin
      slots = rpr_pkg::CNT_W'(2);
    end else if (total_q > rpr_pkg::TOTAL_W'(rpr_pkg::MAX_PAGES)) begin
      slots = rpr_pkg::CNT_W'(rpr_pkg::MAX_PAGES);
    end else begin
      slots = rpr_pkg::CNT_W'(total_q);
    end
  end

  assign lfsr_adv = rpr_pkg::lfsr_next(lfsr_q);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign full     = (fill_q >= slots);
  assign redraw   = last_vld_q && (ram_rdata == last_q) &&
                    (draw_q != rpr_pkg::DRAW_W'(rpr_pkg::MAX_DRAWS - 1));
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = full ? rpr_pkg::ST_DIV : rpr_pkg::ST_WR;
        end
      end
      rpr_pkg::ST_DIV: begin
        if (mod_done) begin
          state_d = rpr_pkg::ST_RD;
        end
      end
      rpr_pkg::ST_RD: begin
        state_d = rpr_pkg::ST_CHK;
      end
      rpr_pkg::ST_CHK: begin
        state_d = redraw ? rpr_pkg::ST_DIV : rpr_pkg::ST_WR;
      end
      rpr_pkg::ST_WR: begin
        if (out_free) begin
          state_d = rpr_pkg::ST_IDLE;
        end
      end
      default: state_d = rpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready_o   = 1'b0;
    mod_start     = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      rpr_pkg::ST_IDLE: begin
        s_axis_tready = !cfg_valid_i;
        cfg_ready_o   = 1'b1;
        mod_start     = s_axis_tvalid && !cfg_valid_i && full;
      end
      rpr_pkg::ST_DIV: begin
      end
      rpr_pkg::ST_RD: begin
        ram_re = 1'b1;
      end
      rpr_pkg::ST_CHK: begin
        mod_start = redraw;
      end
      rpr_pkg::ST_WR: begin
        ram_we   = out_free;
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rpr_pkg::ST_IDLE;
      total_q    <= rpr_pkg::TOTAL_W'(rpr_pkg::MAX_PAGES);
      lfsr_q     <= rpr_pkg::PAGE_W'(1);
      fill_q     <= '0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
      draw_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          rpr_pkg::CFG_TOTAL_PAGES: total_q <= cfg_data_i[rpr_pkg::TOTAL_W-1:0];
          rpr_pkg::CFG_RANDOM_SEED: lfsr_q  <= rpr_pkg::seed_value(cfg_data_i);
          default: begin
          end
        endcase
      end
      if (mod_start) begin
        lfsr_q <= lfsr_adv;
      end
      if (in_fire) begin
        draw_q <= '0;
        if (!full) begin
          fill_q <= fill_q + 1'b1;
        end
      end else if (state_q == rpr_pkg::ST_CHK && redraw) begin
        draw_q <= draw_q + 1'b1;
      end
      if (ram_we) begin
        last_q     <= page_q;
        last_vld_q <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      page_q  <= s_axis_tdata;
      slot_q  <= fill_q[rpr_pkg::SLOT_W-1:0];
      evict_q <= 1'b0;
    end
    if (state_q == rpr_pkg::ST_DIV && mod_done) begin
      slot_q <= mod_rem;
    end
    if (state_q == rpr_pkg::ST_CHK) begin
      victim_q <= ram_rdata;
      evict_q  <= 1'b1;
    end
    if (out_load) begin
      out_evict_q <= evict_q;
      out_page_q  <= evict_q ? victim_q : '0;
      out_slot_q  <= slot_q;
    end
  end

  rpr_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (lfsr_adv),
    .divisor_i  (slots),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  rpr_ram #(
    .WIDTH (rpr_pkg::PAGE_W),
    .DEPTH (rpr_pkg::MAX_PAGES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (page_q),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_evict_q;
  assign m_axis_tdata  = rpr_pkg::OUT_W'({1'b1, 1'b1, out_slot_q, out_page_q});

endmodule

// ===== sv/rpr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rpr_mod.sv =====
// ----------------------------------------------------------------------------
// Serial modulo unit
// Restoring remainder computation, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rpr_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rpr_pkg::PAGE_W-1:0]   dividend_i,
  input  logic [rpr_pkg::CNT_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [rpr_pkg::SLOT_W-1:0]   rem_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [rpr_pkg::STEP_W-1:0]  step_q, step_d;
  logic [rpr_pkg::PAGE_W-1:0]  dvd_q, dvd_d;
  logic [rpr_pkg::CNT_W-1:0]   dvs_q, dvs_d;
  logic [rpr_pkg::SLOT_W-1:0]  rem_q, rem_d;
  logic [rpr_pkg::CNT_W-1:0]   trial;
  logic [rpr_pkg::CNT_W-1:0]   diff;

  assign trial = {rem_q, dvd_q[rpr_pkg::PAGE_W-1]};
  assign diff  = trial - dvs_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= dvs_q) begin
        rem_d = diff[rpr_pkg::SLOT_W-1:0];
      end else begin
        rem_d = trial[rpr_pkg::SLOT_W-1:0];
      end
      step_d = step_q + 1'b1;
      if (step_q == rpr_pkg::STEP_W'(rpr_pkg::PAGE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== dv/random_page_replacement_checker.sv =====
// ----------------------------------------------------------------------------
// Random page replacement checker
// Watches the register, fault and eviction channels of the core. Every fault
// transfer is run through a cycle-free model of the slot table and the LFSR
// draw, and each eviction transfer is compared field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module random_page_replacement_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rpr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          fault_valid_i,
  input  logic                          fault_ready_i,
  input  logic [rpr_pkg::PAGE_W-1:0]    fault_data_i,
  input  logic                          evict_tvalid_i,
  input  logic                          evict_tready_i,
  input  logic [rpr_pkg::OUT_W-1:0]     evict_tdata_i,
  input  logic                          evict_tuser_i,
  output int                            errors_o,
  output int                            outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                         DRAW_LIMIT = 16;
  localparam logic [rpr_pkg::PAGE_W-1:0] FEEDBACK   = 32'h8020_0003;
  localparam int PAD_W = rpr_pkg::OUT_W - rpr_pkg::PAGE_W - rpr_pkg::SLOT_W - 2;

  typedef struct packed {
    logic                          evict;
    logic [rpr_pkg::PAGE_W-1:0]    victim;
    logic [rpr_pkg::SLOT_W-1:0]    slot;
    logic                          dirty;
    logic                          writable;
    logic [PAD_W-1:0]              pad;
  } outcome_t;

  logic [rpr_pkg::PAGE_W-1:0]  page_slots [rpr_pkg::MAX_PAGES];
  logic [rpr_pkg::TOTAL_W-1:0] slot_setting;
  logic [rpr_pkg::PAGE_W-1:0]  rng;
  int unsigned                 filled;
  logic [rpr_pkg::PAGE_W-1:0]  prev_fault;
  logic                        prev_known;
  outcome_t                    pending_q [$];
  outcome_t                    got;
  outcome_t                    want;
  int                          fails;

  function automatic outcome_t place_fault(input logic [rpr_pkg::PAGE_W-1:0] page);
    outcome_t    res;
    int unsigned n;
    int unsigned slot;
    int          draws;
    logic        hunting;
    n = 32'(slot_setting);
    if (n < 2) begin
      n = 2;
    end
    if (n > rpr_pkg::MAX_PAGES) begin
      n = rpr_pkg::MAX_PAGES;
    end
    res          = '0;
    res.dirty    = 1'b1;
    res.writable = 1'b1;
    if (filled < n) begin
      slot   = filled;
      filled = filled + 1;
    end else begin
      slot    = 0;
      hunting = 1'b1;
      for (draws = 0; draws < DRAW_LIMIT && hunting; draws++) begin
        rng  = rng[0] ? ((rng >> 1) ^ FEEDBACK) : (rng >> 1);
        slot = rng % n;
        hunting = prev_known &&
                  (page_slots[rpr_pkg::SLOT_W'(slot)] == prev_fault);
      end
      res.evict  = 1'b1;
      res.victim = page_slots[rpr_pkg::SLOT_W'(slot)];
    end
    res.slot                            = rpr_pkg::SLOT_W'(slot);
    page_slots[rpr_pkg::SLOT_W'(slot)] = page;
    prev_fault                          = page;
    prev_known                          = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_setting = rpr_pkg::TOTAL_W'(1024);
      rng          = 32'd1;
      filled       = 0;
      prev_fault   = '0;
      prev_known   = 1'b0;
      fails        = 0;
      pending_q.delete();
      errors_o      <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == rpr_pkg::CFG_TOTAL_PAGES) begin
          slot_setting = cfg_data_i[rpr_pkg::TOTAL_W-1:0];
        end else if (cfg_index_i == rpr_pkg::CFG_RANDOM_SEED) begin
          rng = (cfg_data_i != '0) ? cfg_data_i : 32'd1;
        end
      end
      if (evict_tvalid_i && evict_tready_i) begin
        got.evict    = evict_tuser_i;
        got.victim   = evict_tdata_i[rpr_pkg::PAGE_W-1:0];
        got.slot     = evict_tdata_i[rpr_pkg::PAGE_W +: rpr_pkg::SLOT_W];
        got.dirty    = evict_tdata_i[rpr_pkg::PAGE_W + rpr_pkg::SLOT_W];
        got.writable = evict_tdata_i[rpr_pkg::PAGE_W + rpr_pkg::SLOT_W + 1];
        got.pad      = evict_tdata_i[rpr_pkg::OUT_W-1 -: PAD_W];
        if (pending_q.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: unexpected transfer: evict=%0b page=%h slot=%0d dirty=%0b wr=%0b",
                     $realtime, got.evict, got.victim, got.slot, got.dirty, got.writable);
          end
          fails++;
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            if (fails < 10) begin
              $display("%0t: mismatch: expected evict=%0b page=%h slot=%0d dirty=%0b wr=%0b pad=%h",
                       $realtime, want.evict, want.victim, want.slot, want.dirty,
                       want.writable, want.pad);
              $display("%0t:            got evict=%0b page=%h slot=%0d dirty=%0b wr=%0b pad=%h",
                       $realtime, got.evict, got.victim, got.slot, got.dirty,
                       got.writable, got.pad);
            end
            fails++;
          end
        end
      end
      if (fault_valid_i && fault_ready_i) begin
        pending_q.push_back(place_fault(fault_data_i));
      end
      errors_o      <= fails;
      outstanding_o <= pending_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Random page replacement testbench
// Drives page faults and register writes into the core under random stalls on
// both streams. A short directed run covers field extremes, slot count
// saturation, the zero seed, ignored register indexes and the forced redraw
// limit; random phases then vary slot count and seed before a last phase
// fills the full table. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int DRAIN_CYCLES  = 600;
  localparam int SMALL_ITEMS   = 620;
  localparam int FULL_ITEMS    = 1100;
  localparam logic [rpr_pkg::CFG_IDX_W-1:0] CFG_RSVD_A = 2'd2;
  localparam logic [rpr_pkg::CFG_IDX_W-1:0] CFG_RSVD_B = 2'd3;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [rpr_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [rpr_pkg::CFG_W-1:0]     cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [rpr_pkg::PAGE_W-1:0]    s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [rpr_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                          m_axis_tuser;

  int                            errors;
  int                            outstanding;
  int                            cycle_count   = 0;
  int                            faults_sent   = 0;
  int                            send_idle_pct = 32;
  int                            recv_idle_pct = 66;
  logic [rpr_pkg::PAGE_W-1:0]    last_fault    = '0;

  random_page_replacement_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  random_page_replacement_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fault_valid_i  (s_axis_tvalid),
    .fault_ready_i  (s_axis_tready),
    .fault_data_i   (s_axis_tdata),
    .evict_tvalid_i (m_axis_tvalid),
    .evict_tready_i (m_axis_tready),
    .evict_tdata_i  (m_axis_tdata),
    .evict_tuser_i  (m_axis_tuser),
    .errors_o       (errors),
    .outstanding_o  (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_fault(input logic [rpr_pkg::PAGE_W-1:0] page);
    if (faults_sent < SMALL_ITEMS / 2) begin
      send_idle_pct = 32;
      recv_idle_pct = 66;
    end else if (faults_sent < SMALL_ITEMS) begin
      send_idle_pct = 66;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= page;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    faults_sent++;
    last_fault = page;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [rpr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpr_pkg::CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_phase(input logic [rpr_pkg::TOTAL_W-1:0] slots,
                           input logic [rpr_pkg::CFG_W-1:0] seed, input bit poke_rsvd);
    logic [rpr_pkg::CFG_W-1:0] word;
    settle();
    word = $urandom;
    if ($urandom_range(1)) begin
      word[rpr_pkg::CFG_W-1:rpr_pkg::TOTAL_W] = '0;
    end
    word[rpr_pkg::TOTAL_W-1:0] = slots;
    if ($urandom_range(1)) begin
      write_reg(rpr_pkg::CFG_TOTAL_PAGES, word);
      write_reg(rpr_pkg::CFG_RANDOM_SEED, seed);
    end else begin
      write_reg(rpr_pkg::CFG_RANDOM_SEED, seed);
      write_reg(rpr_pkg::CFG_TOTAL_PAGES, word);
    end
    if (poke_rsvd) begin
      write_reg(CFG_RSVD_A, $urandom);
      write_reg(CFG_RSVD_B, $urandom);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [rpr_pkg::PAGE_W-1:0] pick_page();
    case ($urandom_range(9))
      0, 1:    return last_fault;
      2, 3:    return rpr_pkg::PAGE_W'($urandom_range(5));
      4:       return $urandom_range(1) ? '0 : '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [rpr_pkg::TOTAL_W-1:0] slots;
    logic [rpr_pkg::CFG_W-1:0]   seed;
    int                          count;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the whole table, so these only fill.
    send_fault(32'h0000_0000);
    send_fault(32'hFFFF_FFFF);
    send_fault(32'h8000_0001);

    // A slot count of zero saturates to two and a zero seed loads one. The
    // repeated page ends up in both slots, which exhausts the redraws.
    set_phase(11'd0, 32'h0, 1'b1);
    repeat (5) send_fault(32'h8000_0001);
    send_fault(32'hAAAA_AAAA);
    send_fault(32'h5555_5555);

    set_phase(11'd1, 32'hFFFF_FFFF, 1'b0);
    send_fault(32'h1234_5678);
    send_fault(32'hFFFF_FFFF);
    send_fault(32'h0000_0000);

    set_phase(11'd5, 32'h0000_0001, 1'b0);
    repeat (4) send_fault(pick_page());

    while (faults_sent < SMALL_ITEMS) begin
      case ($urandom_range(7))
        0:       slots = rpr_pkg::TOTAL_W'($urandom_range(1));
        1:       slots = 11'd2;
        default: slots = rpr_pkg::TOTAL_W'($urandom_range(48, 3));
      endcase
      case ($urandom_range(7))
        0:       seed = '0;
        1:       seed = '1;
        2:       seed = 32'd1;
        default: seed = $urandom;
      endcase
      set_phase(slots, seed, ($urandom_range(3) == 0));
      count = $urandom_range(40, 8);
      repeat (count) send_fault(pick_page());
    end

    case ($urandom_range(2))
      0:       slots = 11'd1024;
      1:       slots = 11'd2047;
      default: slots = rpr_pkg::TOTAL_W'($urandom_range(2047, 1025));
    endcase
    set_phase(slots, $urandom, 1'b1);
    repeat (FULL_ITEMS) send_fault(pick_page());

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
